[src/sdsf_pkg.sv]
// Shared types, segment codes and digit decode for the signed decimal segment formatter.
`timescale 1ns / 1ps

package sdsf_pkg;

	localparam int SegW = 7;

	localparam logic [SegW-1:0] SEG_BLANK = 7'h00;
	localparam logic [SegW-1:0] SEG_MINUS = 7'h40;

	// Thousands digit, remainder below one thousand and sign, between split and digit stages.
	typedef struct packed {
		logic       neg;
		logic [3:0] thou;
		logic [9:0] rem;
	} sdsf_split_t;

	// Decimal digits of the magnitude, each 0..9.
	typedef struct packed {
		logic       neg;
		logic [3:0] thou;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
	} sdsf_digits_t;

	function automatic logic [SegW-1:0] digit_seg(input logic [3:0] d);
		logic [SegW-1:0] s;
		unique case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h21;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h73;
			4'd4:    s = 7'h65;
			4'd5:    s = 7'h76;
			4'd6:    s = 7'h7E;
			4'd7:    s = 7'h23;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h77;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

[src/sdsf_split.sv]
// Magnitude and thousands split stage, registered into stage two.
`timescale 1ns / 1ps

module sdsf_split import sdsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  logic [15:0] value_s1,
	output logic        valid_s2,
	output sdsf_split_t split_s2
);

	logic        neg;
	logic [16:0] mag;
	logic [33:0] q_prod;
	logic [5:0]  q1000;
	logic [16:0] q_back;
	logic [16:0] rem_full;
	logic [9:0]  q10_prod;
	logic [1:0]  q10;
	logic [5:0]  thou_full;
	sdsf_split_t split_d;

	assign neg = value_s1[15];
	// Magnitude reaches 32768 for the most negative value, so keep 17 bits.
	assign mag = neg ? (17'd0 - {1'b1, value_s1}) : {1'b0, value_s1};

	// mag / 1000 by reciprocal 2^26 / 1000 rounded up, exact over the full range
	assign q_prod   = 34'(mag) * 34'd67109;
	assign q1000    = q_prod[31:26];
	assign q_back   = 17'(q1000) * 17'd1000;
	assign rem_full = mag - q_back;

	// quotient stays below 33, so 13/128 gives an exact divide by ten
	assign q10_prod  = 10'(q1000) * 10'd13;
	assign q10       = q10_prod[8:7];
	assign thou_full = q1000 - 6'(q10) * 6'd10;

	always_comb begin
		split_d.neg  = neg;
		split_d.thou = thou_full[3:0];
		split_d.rem  = rem_full[9:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			split_s2 <= split_d;
		end
	end

endmodule

[src/sdsf_digits.sv]
// Hundreds, tens and ones digits from the remainder below one thousand.
`timescale 1ns / 1ps

module sdsf_digits import sdsf_pkg::*; (
	input  sdsf_split_t  split,
	output sdsf_digits_t digits
);

	logic [15:0] h_prod;
	logic [3:0]  hund;
	logic [9:0]  r100_full;
	logic [6:0]  r100;
	logic [14:0] t_prod;
	logic [3:0]  tens;
	logic [6:0]  ones_full;

	// 41/4096 and 205/2048 are exact divides by 100 and 10 below 1024
	assign h_prod    = 16'(split.rem) * 16'd41;
	assign hund      = h_prod[15:12];
	assign r100_full = split.rem - 10'(hund) * 10'd100;
	assign r100      = r100_full[6:0];
	assign t_prod    = 15'(r100) * 15'd205;
	assign tens      = t_prod[14:11];
	assign ones_full = r100 - 7'(tens) * 7'd10;

	always_comb begin
		digits.neg  = split.neg;
		digits.thou = split.thou;
		digits.hund = hund;
		digits.tens = tens;
		digits.ones = ones_full[3:0];
	end

endmodule

[src/sdsf_encode.sv]
// Segment decode with sign placement and leading blank, into the result register.
`timescale 1ns / 1ps

module sdsf_encode import sdsf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s2,
	input  sdsf_digits_t    digits,
	input  logic            point_on,
	output logic            done_q,
	output logic [SegW-1:0] first_q,
	output logic [SegW-1:0] second_q,
	output logic [SegW-1:0] third_q,
	output logic [SegW-1:0] fourth_q,
	output logic            point_q
);

	logic [SegW-1:0] first_d;
	logic [SegW-1:0] second_d;
	logic            thou_nz;
	logic            hund_nz;

	assign thou_nz = (digits.thou != 4'd0);
	assign hund_nz = (digits.hund != 4'd0);

	always_comb begin
		priority if (!digits.neg) begin
			first_d  = thou_nz ? digit_seg(digits.thou) : SEG_BLANK;
			second_d = digit_seg(digits.hund);
		end else if (thou_nz) begin
			// no room for the sign: show both digits
			first_d  = digit_seg(digits.thou);
			second_d = digit_seg(digits.hund);
		end else if (hund_nz) begin
			first_d  = SEG_MINUS;
			second_d = digit_seg(digits.hund);
		end else begin
			first_d  = SEG_BLANK;
			second_d = SEG_MINUS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			first_q  <= first_d;
			second_q <= second_d;
			third_q  <= digit_seg(digits.tens);
			fourth_q <= digit_seg(digits.ones);
			point_q  <= point_on;
		end
	end

endmodule

[src/signed_decimal_segment_formatter_core.sv]
// Top level of the signed decimal four-place seven-segment formatter.
// Usage:
//   Command channel: drive value and raise start; the word is taken at a
//   rising edge with start high and busy low. busy is never raised, so a
//   new value may be issued on every cycle.
//   Result channel: done is high for exactly one cycle with the four
//   segment patterns and point_lit; the receiver must take it then.
//   Pipeline: the accepted word passes the input register, the thousands
//   split with a constant reciprocal multiply, and the digit and segment
//   decode into the result register, which raises done.
//   Throughput: one word per cycle, set by the three-stage pipeline.
//   Configuration: cfg_valid/cfg_ready write decimal_point_on; cfg_ready
//   is always high. Write it only while no word is in flight.
//   Reset: arst_n low clears the pipeline valids and decimal_point_on;
//   no result is produced until a new word is taken.
//   The receiver cannot stall, so nothing is held back.
`timescale 1ns / 1ps

module signed_decimal_segment_formatter_core import sdsf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [15:0]     value,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_data,
	output logic            done,
	output logic [SegW-1:0] first_digit_segments,
	output logic [SegW-1:0] second_digit_segments,
	output logic [SegW-1:0] third_digit_segments,
	output logic [SegW-1:0] fourth_digit_segments,
	output logic            point_lit
);

	logic         dp_on_q;
	logic         valid_s1;
	logic [15:0]  value_s1;
	logic         valid_s2;
	sdsf_split_t  split_s2;
	sdsf_digits_t digits;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_on_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dp_on_q <= cfg_data;
			end
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			value_s1 <= value;
		end
	end

	sdsf_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.value_s1 (value_s1),
		.valid_s2 (valid_s2),
		.split_s2 (split_s2)
	);

	sdsf_digits u_digits (
		.split  (split_s2),
		.digits (digits)
	);

	sdsf_encode u_encode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.digits   (digits),
		.point_on (dp_on_q),
		.done_q   (done),
		.first_q  (first_digit_segments),
		.second_q (second_digit_segments),
		.third_q  (third_digit_segments),
		.fourth_q (fourth_digit_segments),
		.point_q  (point_lit)
	);

`ifndef SYNTH
	// every result traces back to an earlier accepted word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching accepted word");

	a_minus_second: assert property (@(posedge clk) disable iff (!arst_n)
		(done && second_digit_segments == SEG_MINUS) |-> first_digit_segments == SEG_BLANK)
		else $error("minus in second place without blank first place");

	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		(done && first_digit_segments == SEG_MINUS) |->
		(second_digit_segments != SEG_MINUS && second_digit_segments != SEG_BLANK &&
		second_digit_segments != 7'h3F))
		else $error("leading minus must precede a nonzero hundreds digit");
`endif

endmodule

[tb/sv/signed_decimal_segment_formatter_core_tb.sv]
// Self-checking testbench for the signed decimal seven-segment formatter core.
`timescale 1ns / 1ps

module signed_decimal_segment_formatter_core_tb;
	import sdsf_pkg::*;

	localparam int PIPE_DEPTH = 3;
	localparam int STALL_LIMIT = 500;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [SegW-1:0] first;
		logic [SegW-1:0] second;
		logic [SegW-1:0] third;
		logic [SegW-1:0] fourth;
		logic            point;
	} panel_t;

	class display_scoreboard;
		panel_t          awaited[$];
		logic            point_on;
		int              errors;
		int              words;
		int              checked;
		int              minus_first;
		int              minus_second;
		int              neg_unsigned;
		int              lead_blank;
		logic [SegW-1:0] seg_lut [10];

		function new();
			seg_lut = '{7'h3F, 7'h21, 7'h5B, 7'h73, 7'h65, 7'h76, 7'h7E, 7'h23, 7'h7F, 7'h77};
			point_on = 1'b0;
		endfunction

		// Work out the four places and the point for one signed value.
		function panel_t render(logic [15:0] v);
			panel_t      p;
			logic [16:0] mag;
			int          th;
			int          hu;
			int          te;
			int          ones;
			mag = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
			th = (int'(mag) / 1000) % 10;
			hu = (int'(mag) / 100) % 10;
			te = (int'(mag) / 10) % 10;
			ones = int'(mag) % 10;
			if (!v[15]) begin
				p.first = (th != 0) ? seg_lut[th] : SEG_BLANK;
				p.second = seg_lut[hu];
				if (th == 0)
					lead_blank++;
			end else if (th != 0) begin
				// thousands digit takes the first place, so the sign is lost
				p.first = seg_lut[th];
				p.second = seg_lut[hu];
				neg_unsigned++;
			end else if (hu != 0) begin
				p.first = SEG_MINUS;
				p.second = seg_lut[hu];
				minus_first++;
			end else begin
				p.first = SEG_BLANK;
				p.second = SEG_MINUS;
				minus_second++;
			end
			p.third = seg_lut[te];
			p.fourth = seg_lut[ones];
			p.point = point_on;
			return p;
		endfunction

		function void note_word(logic [15:0] v);
			awaited.push_back(render(v));
			words++;
		endfunction

		function void check_result(panel_t got);
			panel_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result %h %h %h %h point %b with no word waiting",
						got.first, got.second, got.third, got.fourth, got.point);
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (got.first !== want.first || got.second !== want.second ||
					got.third !== want.third || got.fourth !== want.fourth ||
					got.point !== want.point) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("mismatch at result %0d: expected %h %h %h %h point %b, got %h %h %h %h point %b",
						checked, want.first, want.second, want.third, want.fourth, want.point,
						got.first, got.second, got.third, got.fourth, got.point);
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic [15:0]     value = '0;
	logic            cfg_valid = 1'b0;
	logic            cfg_data = 1'b0;
	logic            busy;
	logic            cfg_ready;
	logic            done;
	logic [SegW-1:0] first_digit_segments;
	logic [SegW-1:0] second_digit_segments;
	logic [SegW-1:0] third_digit_segments;
	logic [SegW-1:0] fourth_digit_segments;
	logic            point_lit;

	display_scoreboard sb;
	int                quiet_cycles = 0;

	// zero, sign flips, digit rollovers, every sign placement, dropped ten-thousands, extremes
	int corner_values [25] = '{0, 1, -1, 5, -7, 10, -10, 99, -99, 100, -100, -205, 999, -999,
		1000, -1000, -3005, 4680, 9999, 10000, -10000, -10050, 32767, -32768, 12345};

	signed_decimal_segment_formatter_core u_dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.start                 (start),
		.busy                  (busy),
		.value                 (value),
		.cfg_valid             (cfg_valid),
		.cfg_ready             (cfg_ready),
		.cfg_data              (cfg_data),
		.done                  (done),
		.first_digit_segments  (first_digit_segments),
		.second_digit_segments (second_digit_segments),
		.third_digit_segments  (third_digit_segments),
		.fourth_digit_segments (fourth_digit_segments),
		.point_lit             (point_lit)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_word(value);
			if (done)
				sb.check_result(panel_t'({first_digit_segments, second_digit_segments,
					third_digit_segments, fourth_digit_segments, point_lit}));
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	function automatic logic [15:0] pick_value();
		int mag;
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: mag = $urandom_range(0, 1099);
			2: mag = $urandom_range(1, 3) * 10000 + $urandom_range(0, 1099);
			default: mag = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 9)
				: $urandom_range(32760, 32767);
		endcase
		return ($urandom_range(0, 1) == 0) ? 16'(mag) : 16'(-mag);
	endfunction

	task automatic write_point(input logic d);
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.point_on = d;
	endtask

	// Hold start until the word is taken, then maybe idle for a burst.
	task automatic issue_word(input logic [15:0] v, input int idle_pct);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			value <= 16'($urandom);
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic run_random(input int count, input bit calm);
		int idle_pct;
		idle_pct = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				idle_pct = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
			issue_word(pick_value(), idle_pct);
		end
	endtask

	// Drop start and wait out the pipeline before touching the register.
	task automatic settle();
		start <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corner_values[i])
			issue_word(16'(corner_values[i]), 25);
		settle();
		write_point(1'b1);
		foreach (corner_values[i])
			issue_word(16'(corner_values[i]), 0);
		run_random(180, 1'b0);
		settle();
		write_point(1'b0);
		run_random(200, 1'b0);
		settle();
		write_point(1'b1);
		run_random(250, 1'b0);
		run_random(150, 1'b1);
		settle();
		$display("covered %0d words and %0d results with the point off and on, %0d mismatches",
			sb.words, sb.checked, sb.errors);
		$display("leading minus %0d, minus in second place %0d, negative shown unsigned %0d, blank lead %0d",
			sb.minus_first, sb.minus_second, sb.neg_unsigned, sb.lead_blank);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
